[hw/rtl/hrc_pkg.sv]
// Package for the hit rank comparator: shared constants and types.
// No dependencies.
package hrc_pkg;
  localparam int unsigned FieldW = 16;
  localparam int unsigned CountW = 5;

  typedef enum logic [1:0] {
    RegNatural = 2'd0,
    RegOrdered = 2'd1,
    RegFilters = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic decided;
    logic lower;
  } tier_t;
endpackage

[hw/rtl/hrc_key_stage.sv]
// Stage 1: per-key compares (rank, filter scan, float classify, doc id).
// Depends on hrc_pkg.
module hrc_key_stage import hrc_pkg::*; #(
  parameter int unsigned MaxFilters = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic              ordered_i,
  input  logic              natural_i,
  input  logic [CountW-1:0] count_i,
  input  logic [31:0]       doc_a_i,
  input  logic [31:0]       doc_b_i,
  input  logic [31:0]       score_a_i,
  input  logic [31:0]       score_b_i,
  input  logic signed [31:0] rank_a_i,
  input  logic signed [31:0] rank_b_i,
  input  logic [FieldW-1:0] filter_bits_a_i,
  input  logic [FieldW-1:0] filter_bits_b_i,
  output logic              valid_o,
  output tier_t             rank_o,
  output tier_t             filt_o,
  output logic              natural_o,
  output logic              doc_gt_o,
  output logic              nan_o,
  output logic              zeros_o,
  output logic              sa_neg_o,
  output logic              sb_neg_o,
  output logic              mag_lt_o,
  output logic              mag_eq_o
);
  localparam int unsigned Lim = (MaxFilters < FieldW) ? MaxFilters : FieldW;

  logic [FieldW-1:0] mask, ma, mb, diff;
  tier_t rank_d, filt_d;

  always_comb begin
    for (int i = 0; i < FieldW; i++) begin
      mask[i] = (i < Lim) && (CountW'(i) < count_i);
    end
    ma = filter_bits_a_i & mask;
    mb = filter_bits_b_i & mask;
    // first set bit in either; isolate lowest set of (ma|mb)
    diff = (ma | mb) & (~(ma | mb) + FieldW'(1));
    filt_d.decided = |(diff & (ma ^ mb));
    filt_d.lower = |(diff & mb & ~ma);
    rank_d.decided = ordered_i && (rank_a_i != rank_b_i);
    rank_d.lower = rank_a_i > rank_b_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rank_o    <= rank_d;
    filt_o    <= filt_d;
    natural_o <= natural_i;
    doc_gt_o  <= doc_a_i > doc_b_i;
    nan_o     <= ((score_a_i[30:23] == 8'hFF) && (score_a_i[22:0] != '0)) ||
                 ((score_b_i[30:23] == 8'hFF) && (score_b_i[22:0] != '0));
    zeros_o   <= (score_a_i[30:0] == '0) && (score_b_i[30:0] == '0);
    sa_neg_o  <= score_a_i[31];
    sb_neg_o  <= score_b_i[31];
    mag_lt_o  <= score_a_i[30:0] < score_b_i[30:0];
    mag_eq_o  <= score_a_i[30:0] == score_b_i[30:0];
  end
endmodule

[hw/rtl/hrc_base_stage.sv]
// Stage 2: resolves the base key from the stage 1 float and doc flags.
// Depends on hrc_pkg.
module hrc_base_stage import hrc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  input  tier_t rank_i,
  input  tier_t filt_i,
  input  logic  natural_i,
  input  logic  doc_gt_i,
  input  logic  nan_i,
  input  logic  zeros_i,
  input  logic  sa_neg_i,
  input  logic  sb_neg_i,
  input  logic  mag_lt_i,
  input  logic  mag_eq_i,
  output logic  valid_o,
  output tier_t rank_o,
  output tier_t filt_o,
  output logic  base_o
);
  logic eq, lt, base_d;

  always_comb begin
    eq = !nan_i && (zeros_i || ((sa_neg_i == sb_neg_i) && mag_eq_i));
    priority if (nan_i || zeros_i) begin
      lt = 1'b0;
    end else if (sa_neg_i != sb_neg_i) begin
      lt = sa_neg_i;
    end else if (sa_neg_i) begin
      lt = !mag_lt_i && !mag_eq_i;
    end else begin
      lt = mag_lt_i;
    end
    base_d = (natural_i || eq) ? doc_gt_i : lt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rank_o <= rank_i;
    filt_o <= filt_i;
    base_o <= base_d;
  end
endmodule

[hw/rtl/hit_rank_comparator.sv]
// Top level of the hit rank comparator: config registers, three-stage pipe.
// Depends on hrc_pkg, hrc_key_stage, hrc_base_stage.
//
// Usage: drive the eight hit fields with start high; busy is always low,
// so one pair is taken every cycle. The result a_ranks_lower_o appears with
// done_o high for exactly one cycle, after the transfer has passed the registered stages
// (stage 1 key compares, stage 2 base key, stage 3 tier select).
// Throughput is one comparison per cycle; the receiver cannot stall.
// Configuration: cfg_we_i writes cfg_wdata_i to register cfg_idx_i
// (0 natural_order, 1 ordered_query, 2 filter_count); write only while idle.
// Reset clears registers and pipeline valid bits; nothing is in flight.
module hit_rank_comparator import hrc_pkg::*; #(
  parameter int unsigned MaxFilters = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [CountW-1:0] cfg_wdata_i,
  input  logic              start,
  output logic              busy,
  input  logic [31:0]       doc_a_i,
  input  logic [31:0]       doc_b_i,
  input  logic [31:0]       score_a_i,
  input  logic [31:0]       score_b_i,
  input  logic signed [31:0] rank_a_i,
  input  logic signed [31:0] rank_b_i,
  input  logic [FieldW-1:0] filter_bits_a_i,
  input  logic [FieldW-1:0] filter_bits_b_i,
  output logic              done_o,
  output logic              a_ranks_lower_o
);
  logic natural_q, ordered_q;
  logic [CountW-1:0] count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      natural_q <= 1'b0;
      ordered_q <= 1'b0;
      count_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegNatural: natural_q <= cfg_wdata_i[0];
        RegOrdered: ordered_q <= cfg_wdata_i[0];
        RegFilters: count_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic v1, nat1, dgt1, nan1, z1, san1, sbn1, mlt1, meq1;
  tier_t rank1, filt1, rank2, filt2;
  logic v2, base2;

  hrc_key_stage #(.MaxFilters(MaxFilters)) u_key (
    .clk_i, .rst_ni,
    .valid_i(start), .ordered_i(ordered_q), .natural_i(natural_q), .count_i(count_q),
    .doc_a_i, .doc_b_i, .score_a_i, .score_b_i, .rank_a_i, .rank_b_i,
    .filter_bits_a_i, .filter_bits_b_i,
    .valid_o(v1), .rank_o(rank1), .filt_o(filt1), .natural_o(nat1), .doc_gt_o(dgt1),
    .nan_o(nan1), .zeros_o(z1), .sa_neg_o(san1), .sb_neg_o(sbn1),
    .mag_lt_o(mlt1), .mag_eq_o(meq1)
  );

  hrc_base_stage u_base (
    .clk_i, .rst_ni, .valid_i(v1), .rank_i(rank1), .filt_i(filt1),
    .natural_i(nat1), .doc_gt_i(dgt1), .nan_i(nan1), .zeros_i(z1),
    .sa_neg_i(san1), .sb_neg_i(sbn1), .mag_lt_i(mlt1), .mag_eq_i(meq1),
    .valid_o(v2), .rank_o(rank2), .filt_o(filt2), .base_o(base2)
  );

  logic done_q, lower_q, lower_d;

  always_comb begin
    priority if (rank2.decided) begin
      lower_d = rank2.lower;
    end else if (filt2.decided) begin
      lower_d = filt2.lower;
    end else begin
      lower_d = base2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= v2;
    end
  end

  always_ff @(posedge clk_i) begin
    lower_q <= lower_d;
  end

  assign done_o = done_q;
  assign a_ranks_lower_o = lower_q;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> ##3 done_o) else $error("result lost");
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, 3)) else $error("spurious result");
  a_rank_wins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2 && rank2.decided) |=> (a_ranks_lower_o == $past(rank2.lower)))
    else $error("rank tier overridden");
endmodule

[verif/tb_hit_rank_comparator.sv]
// Testbench for hit_rank_comparator: directed and random hit pairs under several
// register settings and idle patterns, checked against an in-bench predictor.
// Depends on hrc_pkg and the hit_rank_comparator RTL.
module tb_hit_rank_comparator;
  import hrc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0] doc_a, doc_b, score_a, score_b;
    logic signed [31:0] rank_a, rank_b;
    logic [FieldW-1:0] fbits_a, fbits_b;
  } hit_pair_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  logic [CountW-1:0] cfg_wdata_i = '0;
  logic start = 1'b0;
  logic busy;
  logic [31:0] doc_a_i = '0, doc_b_i = '0, score_a_i = '0, score_b_i = '0;
  logic signed [31:0] rank_a_i = '0, rank_b_i = '0;
  logic [FieldW-1:0] filter_bits_a_i = '0, filter_bits_b_i = '0;
  logic done_o, a_ranks_lower_o;

  hit_rank_comparator dut (.*);

  hit_pair_t pending_pairs[$];
  logic      expected_lower[$];
  int        sender_idle_pct = 0;
  int        pairs_sent = 0, verdicts_checked = 0, errors = 0, phases = 0;
  logic      by_doc_only = 1'b0, rank_first = 1'b0;
  logic [CountW-1:0] filters_set = '0;

  initial forever #2 clk_i = ~clk_i;

  function automatic logic is_nan(logic [31:0] f);
    return f[30:23] == 8'hFF && f[22:0] != 0;
  endfunction

  function automatic logic score_equal(logic [31:0] a, logic [31:0] b);
    if (is_nan(a) || is_nan(b)) return 1'b0;
    return a == b || (a[30:0] == 0 && b[30:0] == 0);
  endfunction

  function automatic logic score_less(logic [31:0] a, logic [31:0] b);
    if (is_nan(a) || is_nan(b) || score_equal(a, b)) return 1'b0;
    if (a[31] != b[31]) return a[31];
    return a[31] ? (a[30:0] > b[30:0]) : (a[30:0] < b[30:0]);
  endfunction

  function automatic logic predict_a_lower(hit_pair_t p);
    int n;
    n = filters_set > FieldW ? FieldW : filters_set;
    if (rank_first && p.rank_a != p.rank_b) return p.rank_a > p.rank_b;
    for (int i = 0; i < n; i++) begin
      if (p.fbits_a[i] && p.fbits_b[i]) break;
      if (p.fbits_a[i]) return 1'b0;
      if (p.fbits_b[i]) return 1'b1;
    end
    if (by_doc_only || score_equal(p.score_a, p.score_b)) return p.doc_a > p.doc_b;
    return score_less(p.score_a, p.score_b);
  endfunction

  function automatic logic [31:0] pick_score(logic [31:0] other);
    case ($urandom_range(9))
      0: return 32'h0000_0000;
      1: return 32'h8000_0000;
      2: return {1'($urandom_range(1)), 8'hFF, 23'h0};
      3: return {1'($urandom_range(1)), 8'hFF, 23'($urandom_range(1, 32'h7F_FFFF))};
      4: return {1'($urandom_range(1)), 8'h00, 23'($urandom())};
      5, 6: return other;
      7: return other ^ 32'h8000_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic hit_pair_t random_pair();
    hit_pair_t p;
    p.doc_a = $urandom();
    p.doc_b = $urandom_range(2) == 0 ? p.doc_a : $urandom();
    p.score_a = $urandom();
    p.score_b = pick_score(p.score_a);
    p.score_a = pick_score(p.score_b);
    p.rank_a = $urandom_range(3) == 0 ? 32'sh8000_0000 : $urandom_range(3) == 0
               ? 32'sh7FFF_FFFF : $urandom_range(1) ? $urandom() : $urandom_range(4);
    p.rank_b = $urandom_range(1) ? p.rank_a : $urandom_range(1) ? $urandom()
               : $urandom_range(4);
    p.fbits_a = FieldW'($urandom() & $urandom() & $urandom());
    p.fbits_b = $urandom_range(2) == 0 ? p.fbits_a : FieldW'($urandom() & $urandom());
    if ($urandom_range(3) == 0) p.fbits_a = FieldW'($urandom());
    return p;
  endfunction

  function automatic hit_pair_t make_pair(logic [31:0] da, db, sa, sb, ra, rb,
                                          logic [15:0] fa, fb);
    hit_pair_t p;
    p.doc_a = da; p.doc_b = db; p.score_a = sa; p.score_b = sb;
    p.rank_a = ra; p.rank_b = rb; p.fbits_a = fa; p.fbits_b = fb;
    return p;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_lower.push_back(predict_a_lower('{doc_a_i, doc_b_i, score_a_i,
          score_b_i, rank_a_i, rank_b_i, filter_bits_a_i, filter_bits_b_i}));
        pairs_sent++;
      end
      if (pending_pairs.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        hit_pair_t p;
        p = pending_pairs.pop_front();
        doc_a_i <= p.doc_a; doc_b_i <= p.doc_b;
        score_a_i <= p.score_a; score_b_i <= p.score_b;
        rank_a_i <= p.rank_a; rank_b_i <= p.rank_b;
        filter_bits_a_i <= p.fbits_a; filter_bits_b_i <= p.fbits_b;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_lower.size() == 0) begin
        $error("unexpected transfer: a_ranks_lower=%0b", a_ranks_lower_o);
        errors++;
      end else begin
        logic e;
        e = expected_lower.pop_front();
        verdicts_checked++;
        if (a_ranks_lower_o !== e) begin
          $error("a_ranks_lower: expected %0b, actual %0b", e, a_ranks_lower_o);
          errors++;
        end
      end
    end
  end

  task automatic write_reg(reg_idx_e idx, logic [CountW-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegNatural: by_doc_only = val[0];
      RegOrdered: rank_first = val[0];
      default:    filters_set = val;
    endcase
  endtask

  task automatic drain();
    while (pending_pairs.size() != 0 || start || expected_lower.size() != 0)
      @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic run_phase(logic nat, logic ord, logic [CountW-1:0] fc, int idle, int n);
    write_reg(RegNatural, CountW'(nat));
    write_reg(RegOrdered, CountW'(ord));
    write_reg(RegFilters, fc);
    sender_idle_pct = idle;
    repeat (n) pending_pairs.push_back(random_pair());
    drain();
    phases++;
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    // defaults: relevance mode, no rank, no filters
    pending_pairs.push_back(make_pair(0, 0, 0, 32'h8000_0000, 0, 0, 0, 0));
    pending_pairs.push_back(make_pair('1, 0, 32'h3F80_0000, 32'h3F80_0000, 0, 0, 0, 0));
    pending_pairs.push_back(make_pair(5, 9, 32'h7FC0_0000, 32'h3F80_0000, 0, 0, 0, 0));
    pending_pairs.push_back(make_pair(9, 5, 32'h7FC0_0000, 32'h7FC0_0000, 0, 0, 0, 0));
    pending_pairs.push_back(make_pair(1, 2, 32'hFF80_0000, 32'h7F80_0000, 0, 0, 0, 0));
    pending_pairs.push_back(make_pair(1, 2, 32'hBF80_0000, 32'hC000_0000, 0, 0, 0, 0));
    pending_pairs.push_back(make_pair(7, 7, 32'h1234_5678, 32'h1234_5678, 3, 3, '1, '1));
    drain();
    write_reg(RegOrdered, 1);
    write_reg(RegFilters, 16);
    pending_pairs.push_back(make_pair(0, 1, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0));
    pending_pairs.push_back(make_pair(0, 1, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0));
    pending_pairs.push_back(make_pair(0, 1, 0, 0, 4, 4, 16'h8000, 0));
    pending_pairs.push_back(make_pair(0, 1, 0, 0, 4, 4, 0, 16'h8000));
    pending_pairs.push_back(make_pair(0, 1, 0, 0, 4, 4, 16'h0001, 16'h0001));
    pending_pairs.push_back(make_pair(0, 1, 0, 0, 4, 4, 16'h0003, 16'h0001));
    drain();
    write_reg(RegFilters, 31);
    write_reg(RegNatural, 1);
    pending_pairs.push_back(make_pair('1, 0, 0, 32'h3F80_0000, 4, 4, 16'h8000, 16'h4000));
    pending_pairs.push_back(make_pair(0, '1, 32'h3F80_0000, 0, 4, 4, 0, 0));
    pending_pairs.push_back(make_pair(3, 3, 32'h7FC0_0000, 0, 4, 4, 0, 0));
    drain();
    run_phase(0, 0, 0, 0, 220);
    run_phase(1, 1, 16, 86, 220);
    run_phase(0, 1, 3, 0, 220);
    run_phase(1, 0, 31, 31, 220);
    run_phase(0, 0, 16, 86, 220);
    run_phase(0, 1, 1, 31, 220);
    run_phase(1, 1, 0, 0, 220);
    run_phase(0, 0, 8, 86, 220);
    $display("Checked %0d comparisons over %0d register settings,", verdicts_checked, phases);
    $display("including sign, NaN, zero, rank and filter corner pairs.");
    if (errors == 0) begin
      $display("hit_rank_comparator: match");
    end else begin
      $display("hit_rank_comparator: mismatch");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("hit_rank_comparator: mismatch");
    $finish;
  end
endmodule
